FILE: rtl/tct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection tracker package
// Table size, protocol constants and the shared types of the tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int CONN_ENTRIES = 16;
  localparam int IDX_W        = $clog2(CONN_ENTRIES);
  localparam int CNT_W        = $clog2(CONN_ENTRIES + 1);

  localparam logic [31:0] OWN_ADDRESS_RESET = 32'd167772687;
  localparam logic [31:0] ISN_RECEIVED      = 32'd1000;
  localparam logic [15:0] EPHEMERAL_LOW     = 16'd49152;
  localparam logic [15:0] EPHEMERAL_HIGH    = 16'd65535;

  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_ACK = 4;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_OPEN    = 2'd1,
    OP_SEND    = 2'd2,
    OP_CLOSE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STATUS_UPDATED         = 3'd0,
    STATUS_CREATED         = 3'd1,
    STATUS_NO_MATCH        = 3'd2,
    STATUS_TABLE_FULL      = 3'd3,
    STATUS_NOT_ESTABLISHED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CS_SYN_SENT     = 3'd0,
    CS_SYN_RECEIVED = 3'd1,
    CS_ESTABLISHED  = 3'd2,
    CS_FIN_WAIT1    = 3'd3,
    CS_FIN_WAIT2    = 3'd4,
    CS_CLOSE_WAIT   = 3'd5,
    CS_NONE         = 3'd7
  } conn_state_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SCAN   = 2'd1,
    FSM_DECIDE = 2'd2
  } fsm_t;

  typedef struct packed {
    logic [31:0] remote_addr;
    logic [31:0] local_addr;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [31:0] send_seq;
    logic [31:0] ack;
    conn_state_t state;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] remote_address;
    logic [31:0] local_address;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [31:0] sequence_in;
    logic [7:0]  tcp_flags;
    logic [15:0] payload_length;
  } item_t;

endpackage

FILE: rtl/tct_channels_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection tracker channels
// Event channel into the tracker and result channel out of it.
// ----------------------------------------------------------------------------
interface tct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] remote_address;
  logic [31:0] local_address;
  logic [15:0] peer_port;
  logic [15:0] own_port;
  logic [31:0] sequence_in;
  logic [7:0]  tcp_flags;
  logic [15:0] payload_length;

  modport source (
    output valid, op, remote_address, local_address, peer_port, own_port,
           sequence_in, tcp_flags, payload_length,
    input  ready
  );
  modport sink (
    input  valid, op, remote_address, local_address, peer_port, own_port,
           sequence_in, tcp_flags, payload_length,
    output ready
  );
endinterface

interface tct_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  conn_state;
  logic [3:0]  entry_index;
  logic [31:0] send_sequence;
  logic [31:0] ack_value;
  logic [15:0] assigned_port;

  modport source (
    output valid, status, conn_state, entry_index, send_sequence, ack_value,
           assigned_port,
    input  ready
  );
  modport sink (
    input  valid, status, conn_state, entry_index, send_sequence, ack_value,
           assigned_port,
    output ready
  );
endinterface

FILE: rtl/tcp_connection_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection tracker
// Connection table in a synchronous memory with one read and one write port, with a serial lookup.
// ----------------------------------------------------------------------------
// Each event beat produces one result beat. Entries fill the table from slot
// zero upwards and are never freed, so a fill count stands in for valid bits
// and no clearing pass is needed after reset. A segment, send or close event
// searches the filled slots newest first through the one memory read port,
// one slot per cycle, and stops at the first match; the result is then
// registered from the decide state. An open event does no search and goes
// from acceptance straight to the decide state. One event is in work at a
// time; the next is accepted once the result has been placed in the output
// register, so a result beat that is not taken holds the event in the decide
// state.
module tcp_connection_tracker
  import tct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  tct_req_if.sink     req,
  tct_rsp_if.source   rsp
);

  entry_t             mem [CONN_ENTRIES];
  entry_t             rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic [31:0]        own_address;
  logic [CNT_W-1:0]   fill_count;
  logic [15:0]        ephemeral_port;
  fsm_t               state;
  fsm_t               state_next;
  item_t              item;
  logic [IDX_W-1:0]   chk_idx;
  logic [IDX_W-1:0]   chk_idx_next;
  logic               found;
  logic               found_next;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   slot_next;
  logic               load_item;
  logic               commit;
  logic               fill_inc;
  logic               port_adv;

  logic               rsp_valid;
  logic [2:0]         rsp_status;
  logic [2:0]         rsp_conn_state;
  logic [3:0]         rsp_entry_index;
  logic [31:0]        rsp_send_sequence;
  logic [31:0]        rsp_ack_value;
  logic [15:0]        rsp_assigned_port;

  status_t            res_status;
  logic               res_ok;
  entry_t             res_ent;
  logic [IDX_W-1:0]   res_idx;
  logic               do_write;
  logic               do_fill;
  logic               do_port;
  entry_t             upd;
  logic               table_full;
  logic [IDX_W-1:0]   new_idx;
  logic               match;
  item_t              req_item;

  assign req_item = '{
    op:             op_t'(req.op),
    remote_address: req.remote_address,
    local_address:  req.local_address,
    peer_port:      req.peer_port,
    own_port:       req.own_port,
    sequence_in:    req.sequence_in,
    tcp_flags:      req.tcp_flags,
    payload_length: req.payload_length
  };

  assign req.ready = (state == FSM_IDLE);

  assign table_full = (fill_count == CNT_W'(CONN_ENTRIES));
  assign new_idx    = IDX_W'(fill_count);
  assign match      = (rd_data.remote_addr == item.remote_address) &&
                      (rd_data.own_port == item.own_port) &&
                      (rd_data.peer_port == item.peer_port);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Result of the event, worked out from the latched item and the entry read.
  always_comb begin
    res_status = STATUS_NO_MATCH;
    res_ok     = 1'b0;
    res_ent    = rd_data;
    res_idx    = slot;
    do_write   = 1'b0;
    do_fill    = 1'b0;
    do_port    = 1'b0;
    upd        = rd_data;
    unique case (item.op)
      OP_SEGMENT: begin
        if (item.tcp_flags[FLAG_SYN]) begin
          if (found) begin
            res_status = STATUS_UPDATED;
            res_ok     = 1'b1;
          end else if (table_full) begin
            res_status = STATUS_TABLE_FULL;
          end else begin
            upd = '{
              remote_addr: item.remote_address,
              local_addr:  item.local_address,
              peer_port:   item.peer_port,
              own_port:    item.own_port,
              send_seq:    ISN_RECEIVED,
              ack:         item.sequence_in + 32'd1,
              state:       CS_SYN_RECEIVED
            };
            res_status = STATUS_CREATED;
            res_ok     = 1'b1;
            res_ent    = upd;
            res_idx    = new_idx;
            do_write   = 1'b1;
            do_fill    = 1'b1;
          end
        end else if (found) begin
          upd.ack = item.sequence_in + 32'd1;
          if (item.tcp_flags[FLAG_ACK]) begin
            if (rd_data.state == CS_SYN_RECEIVED) begin
              upd.state = CS_ESTABLISHED;
            end else if (rd_data.state == CS_FIN_WAIT1) begin
              upd.state = CS_FIN_WAIT2;
            end
          end
          if (item.tcp_flags[FLAG_FIN]) begin
            upd.state = CS_CLOSE_WAIT;
          end
          res_status = STATUS_UPDATED;
          res_ok     = 1'b1;
          res_ent    = upd;
          do_write   = 1'b1;
        end
      end
      OP_OPEN: begin
        if (table_full) begin
          res_status = STATUS_TABLE_FULL;
        end else begin
          upd = '{
            remote_addr: item.remote_address,
            local_addr:  own_address,
            peer_port:   item.peer_port,
            own_port:    ephemeral_port,
            send_seq:    item.sequence_in + 32'd1,
            ack:         32'd0,
            state:       CS_SYN_SENT
          };
          res_status = STATUS_CREATED;
          res_ok     = 1'b1;
          res_ent    = upd;
          res_idx    = new_idx;
          do_write   = 1'b1;
          do_fill    = 1'b1;
          do_port    = 1'b1;
        end
      end
      OP_SEND: begin
        if (found) begin
          res_ok = 1'b1;
          if (rd_data.state != CS_ESTABLISHED) begin
            res_status = STATUS_NOT_ESTABLISHED;
          end else begin
            upd.send_seq = rd_data.send_seq + {16'd0, item.payload_length};
            res_status   = STATUS_UPDATED;
            res_ent      = upd;
            do_write     = 1'b1;
          end
        end
      end
      OP_CLOSE: begin
        if (found) begin
          upd.state  = CS_FIN_WAIT1;
          res_status = STATUS_UPDATED;
          res_ok     = 1'b1;
          res_ent    = upd;
          do_write   = 1'b1;
        end
      end
      default: begin
        res_status = STATUS_NO_MATCH;
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    rd_en        = 1'b0;
    rd_addr      = chk_idx;
    chk_idx_next = chk_idx;
    found_next   = found;
    slot_next    = slot;
    load_item    = 1'b0;
    commit       = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        if (req.valid) begin
          load_item  = 1'b1;
          found_next = 1'b0;
          if (req_item.op == OP_OPEN || fill_count == '0) begin
            state_next = FSM_DECIDE;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = IDX_W'(fill_count - CNT_W'(1));
            chk_idx_next = rd_addr;
            state_next   = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        if (match) begin
          found_next = 1'b1;
          slot_next  = chk_idx;
          state_next = FSM_DECIDE;
        end else if (chk_idx == '0) begin
          state_next = FSM_DECIDE;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = chk_idx - IDX_W'(1);
          chk_idx_next = rd_addr;
        end
      end
      FSM_DECIDE: begin
        if (!rsp_valid || rsp.ready) begin
          commit     = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  assign wr_en    = commit && do_write;
  assign wr_addr  = res_idx;
  assign wr_data  = upd;
  assign fill_inc = commit && do_fill;
  assign port_adv = commit && do_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= FSM_IDLE;
      own_address    <= OWN_ADDRESS_RESET;
      fill_count     <= '0;
      ephemeral_port <= EPHEMERAL_LOW;
      found          <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
      if (cfg_write) begin
        own_address <= cfg_data;
      end
      if (fill_inc) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      if (port_adv) begin
        if (ephemeral_port == EPHEMERAL_HIGH) begin
          ephemeral_port <= EPHEMERAL_LOW;
        end else begin
          ephemeral_port <= ephemeral_port + 16'd1;
        end
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      item <= req_item;
    end
    chk_idx <= chk_idx_next;
    slot    <= slot_next;
    if (commit) begin
      rsp_status <= res_status;
      if (res_ok) begin
        rsp_conn_state    <= res_ent.state;
        rsp_entry_index   <= 4'(res_idx);
        rsp_send_sequence <= res_ent.send_seq;
        rsp_ack_value     <= res_ent.ack;
        rsp_assigned_port <= res_ent.own_port;
      end else begin
        rsp_conn_state    <= CS_NONE;
        rsp_entry_index   <= 4'd0;
        rsp_send_sequence <= 32'd0;
        rsp_ack_value     <= 32'd0;
        rsp_assigned_port <= 16'd0;
      end
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.conn_state    = rsp_conn_state;
  assign rsp.entry_index   = rsp_entry_index;
  assign rsp.send_sequence = rsp_send_sequence;
  assign rsp.ack_value     = rsp_ack_value;
  assign rsp.assigned_port = rsp_assigned_port;

endmodule
